FILE: rtl/multi_level_sensor_stats_aggregator_assert.svh
// assertion macros used by the aggregator rtl
`ifndef MULTI_LEVEL_SENSOR_STATS_AGGREGATOR_ASSERT_SVH
`define MULTI_LEVEL_SENSOR_STATS_AGGREGATOR_ASSERT_SVH

`ifndef ASSERT_OFF
// property checked on every rising clock edge outside reset
`define MSA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// implication checked on every rising clock edge outside reset
`define MSA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define MSA_ASSERT(lbl, clk, rstn, prop)
`define MSA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/msa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package msa_pkg;

  localparam int unsigned DATA_W  = 16;
  localparam int unsigned CH_W    = 3;
  localparam int unsigned LVL_W   = 3;
  localparam int unsigned USED_W  = 6;
  localparam int unsigned LIMIT_W = 4;
  // entry counts up to 64 and the sum of 64 samples
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned SUM_W   = 23;

  localparam logic [LVL_W-1:0] LVL_MINUTE = 3'd1;
  localparam logic [LVL_W-1:0] LVL_TENMIN = 3'd2;
  localparam logic [LVL_W-1:0] LVL_HOUR   = 3'd3;
  localparam logic [LVL_W-1:0] LVL_DAY    = 3'd4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd4;

  typedef struct packed {
    logic [CH_W-1:0]          channel;
    logic signed [DATA_W-1:0] sample;
    logic                     sample_valid;
    logic                     hold_sample;
    logic [LVL_W-1:0]         rollup_level;
  } in_t;

  typedef struct packed {
    logic [CH_W-1:0]          out_channel;
    logic [LVL_W-1:0]         level;
    logic signed [DATA_W-1:0] average;
    logic signed [DATA_W-1:0] minimum;
    logic signed [DATA_W-1:0] maximum;
    logic [USED_W-1:0]        entries_used;
  } out_t;

  typedef enum logic [4:0] {
    ST_CLR  = 5'b00001,
    ST_IDLE = 5'b00010,
    ST_PRE  = 5'b00100,
    ST_SCAN = 5'b01000,
    ST_DIV  = 5'b10000
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/multi_level_sensor_stats_aggregator.sv
`timescale 1ns / 1ps
`default_nettype none

// Per-channel sensor statistics in four levels (seconds, minutes, ten-minutes, hours).
// An item is taken with start while busy is low; busy stays high until the item is done.
// After reset the block runs a clearing pass over all 2**(channel bits + widest index
// bits) store addresses (512 with the defaults), with busy high; config writes are
// taken during it. A rollup makes one store read per cycle through the level's
// memory port for each of the n lower level entries (at least 1), then passes
// through the shift divider. The result appears on result_o with result_valid_o
// high for exactly one cycle and cannot be held off by the receiver.
`include "multi_level_sensor_stats_aggregator_assert.svh"

module multi_level_sensor_stats_aggregator #(
  parameter int unsigned CHANNELS     = 8,
  parameter int unsigned SECOND_DEPTH = 60,
  parameter int unsigned MINUTE_DEPTH = 10,
  parameter int unsigned TENMIN_DEPTH = 6,
  parameter int unsigned HOUR_DEPTH   = 24
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire msa_pkg::in_t                    item_i,
  output logic                                 result_valid_o,
  output msa_pkg::out_t                        result_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [msa_pkg::LIMIT_W-1:0]     cfg_data_i
);

  localparam int unsigned CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SIW = (SECOND_DEPTH > 1) ? $clog2(SECOND_DEPTH) : 1;
  localparam int unsigned MIW = (MINUTE_DEPTH > 1) ? $clog2(MINUTE_DEPTH) : 1;
  localparam int unsigned TIW = (TENMIN_DEPTH > 1) ? $clog2(TENMIN_DEPTH) : 1;
  localparam int unsigned HIW = (HOUR_DEPTH > 1) ? $clog2(HOUR_DEPTH) : 1;
  localparam int unsigned SCW = $clog2(SECOND_DEPTH + 1);
  localparam int unsigned MCW = $clog2(MINUTE_DEPTH + 1);
  localparam int unsigned TCW = $clog2(TENMIN_DEPTH + 1);
  localparam int unsigned HCW = $clog2(HOUR_DEPTH + 1);
  localparam int unsigned SAW = CW + SIW;
  localparam int unsigned MAW = CW + MIW;
  localparam int unsigned TAW = CW + TIW;
  localparam int unsigned HAW = CW + HIW;
  localparam int unsigned AW1 = (SAW > MAW) ? SAW : MAW;
  localparam int unsigned AW2 = (TAW > HAW) ? TAW : HAW;
  localparam int unsigned CLR_AW = (AW1 > AW2) ? AW1 : AW2;
  localparam int unsigned DW  = msa_pkg::DATA_W;
  localparam int unsigned LW  = 3 * msa_pkg::DATA_W;

  msa_pkg::state_e state_q, state_d;
  msa_pkg::in_t    item_q, item_d;
  logic [CW-1:0]   ch_q, ch_d;
  logic [msa_pkg::CNT_W-1:0] n_q, n_d, idx_q, idx_d, n_eff;
  logic            rd_vld_q, rd_vld_d, first_q, first_d;
  logic signed [msa_pkg::SUM_W-1:0] sum_q, sum_d;
  logic signed [DW-1:0] min_q, min_d, max_q, max_d;
  logic [CLR_AW-1:0] clr_q, clr_d;
  logic [msa_pkg::LIMIT_W-1:0] limit_q, limit_d;
  logic [msa_pkg::LIMIT_W-1:0] miss_q [CHANNELS];
  logic [msa_pkg::LIMIT_W-1:0] miss_d [CHANNELS];
  logic [SCW-1:0]  scnt_q [CHANNELS];
  logic [SCW-1:0]  scnt_d [CHANNELS];
  logic [MCW-1:0]  mcnt_q [CHANNELS];
  logic [MCW-1:0]  mcnt_d [CHANNELS];
  logic [TCW-1:0]  tcnt_q [CHANNELS];
  logic [TCW-1:0]  tcnt_d [CHANNELS];
  logic [HCW-1:0]  hcnt_q [CHANNELS];
  logic [HCW-1:0]  hcnt_d [CHANNELS];
  logic [SCW-1:0]  scnt_new;
  logic [msa_pkg::LIMIT_W-1:0] miss_inc;
  msa_pkg::out_t   res_q, res_d;
  logic            res_vld_q, res_vld_d;

  // memory ports
  logic           sec_we, sec_re, min_we, min_re, ten_we, ten_re, hr_we, hr_re;
  logic [SAW-1:0] sec_waddr, sec_raddr;
  logic [MAW-1:0] min_waddr, min_raddr;
  logic [TAW-1:0] ten_waddr, ten_raddr;
  logic [HAW-1:0] hr_waddr, hr_raddr;
  logic [DW-1:0]  sec_wdata, sec_rdata;
  logic [LW-1:0]  lvl_wdata, min_wdata, ten_wdata, hr_wdata;
  logic [LW-1:0]  min_rdata, ten_rdata, hr_rdata;
  logic signed [DW-1:0] rd_avg, rd_min, rd_max, avg_res;

  logic           div_start, div_done;
  logic signed [DW-1:0] div_quot;

  // read data of the level under rollup
  always_comb begin
    unique case (item_q.rollup_level)
      msa_pkg::LVL_MINUTE: begin
        rd_avg = sec_rdata;
        rd_min = sec_rdata;
        rd_max = sec_rdata;
      end
      msa_pkg::LVL_TENMIN: begin
        rd_avg = min_rdata[LW-1 -: DW];
        rd_min = min_rdata[2*DW-1 -: DW];
        rd_max = min_rdata[DW-1:0];
      end
      msa_pkg::LVL_HOUR: begin
        rd_avg = ten_rdata[LW-1 -: DW];
        rd_min = ten_rdata[2*DW-1 -: DW];
        rd_max = ten_rdata[DW-1:0];
      end
      default: begin
        rd_avg = hr_rdata[LW-1 -: DW];
        rd_min = hr_rdata[2*DW-1 -: DW];
        rd_max = hr_rdata[DW-1:0];
      end
    endcase
  end

  assign n_eff     = (n_q == '0) ? msa_pkg::CNT_W'(1) : n_q;
  assign avg_res   = (n_q == '0) ? '0 : div_quot;
  assign lvl_wdata = {avg_res, min_q, max_q};
  assign scnt_new  = scnt_q[ch_q] + 1'b1;
  assign miss_inc  = miss_q[ch_q] + 1'b1;

  // sequencer: store clear, sample update, store scan, divide and append
  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    ch_d      = ch_q;
    n_d       = n_q;
    idx_d     = idx_q;
    rd_vld_d  = 1'b0;
    first_d   = first_q;
    sum_d     = sum_q;
    min_d     = min_q;
    max_d     = max_q;
    clr_d     = clr_q;
    limit_d   = cfg_valid_i ? cfg_data_i : limit_q;
    miss_d    = miss_q;
    scnt_d    = scnt_q;
    mcnt_d    = mcnt_q;
    tcnt_d    = tcnt_q;
    hcnt_d    = hcnt_q;
    res_d     = res_q;
    res_vld_d = 1'b0;
    div_start = 1'b0;
    sec_we    = 1'b0;
    sec_waddr = {ch_q, scnt_q[ch_q][SIW-1:0]};
    sec_wdata = item_q.sample;
    min_we    = 1'b0;
    min_waddr = {ch_q, mcnt_q[ch_q][MIW-1:0]};
    min_wdata = lvl_wdata;
    ten_we    = 1'b0;
    ten_waddr = {ch_q, tcnt_q[ch_q][TIW-1:0]};
    ten_wdata = lvl_wdata;
    hr_we     = 1'b0;
    hr_waddr  = {ch_q, hcnt_q[ch_q][HIW-1:0]};
    hr_wdata  = lvl_wdata;
    sec_re    = 1'b0;
    min_re    = 1'b0;
    ten_re    = 1'b0;
    hr_re     = 1'b0;
    sec_raddr = {ch_q, idx_q[SIW-1:0]};
    min_raddr = {ch_q, idx_q[MIW-1:0]};
    ten_raddr = {ch_q, idx_q[TIW-1:0]};
    hr_raddr  = {ch_q, idx_q[HIW-1:0]};

    unique case (state_q)
      msa_pkg::ST_CLR: begin
        // zero every entry of every store
        sec_we    = 1'b1;
        min_we    = 1'b1;
        ten_we    = 1'b1;
        hr_we     = 1'b1;
        sec_waddr = clr_q[SAW-1:0];
        min_waddr = clr_q[MAW-1:0];
        ten_waddr = clr_q[TAW-1:0];
        hr_waddr  = clr_q[HAW-1:0];
        sec_wdata = '0;
        min_wdata = '0;
        ten_wdata = '0;
        hr_wdata  = '0;
        clr_d     = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = msa_pkg::ST_IDLE;
        end
      end
      msa_pkg::ST_IDLE: begin
        if (start && (32'(item_i.channel) < CHANNELS)) begin
          item_d  = item_i;
          ch_d    = CW'(item_i.channel);
          state_d = msa_pkg::ST_PRE;
        end
      end
      msa_pkg::ST_PRE: begin
        // sample push or miss handling
        if (!item_q.hold_sample) begin
          if (item_q.sample_valid) begin
            if (32'(scnt_q[ch_q]) < SECOND_DEPTH) begin
              sec_we        = 1'b1;
              scnt_d[ch_q]  = scnt_new;
            end
            miss_d[ch_q] = '0;
          end else if (miss_inc >= limit_q) begin
            miss_d[ch_q] = '0;
            sec_we       = 1'b1;
            sec_waddr    = {ch_q, SIW'(0)};
            sec_wdata    = '0;
          end else begin
            miss_d[ch_q] = miss_inc;
          end
        end
        // pick the level to roll up and empty it
        idx_d   = '0;
        first_d = 1'b1;
        sum_d   = '0;
        state_d = msa_pkg::ST_SCAN;
        unique case (item_q.rollup_level)
          msa_pkg::LVL_MINUTE: begin
            n_d          = msa_pkg::CNT_W'(scnt_d[ch_q]);
            scnt_d[ch_q] = '0;
          end
          msa_pkg::LVL_TENMIN: begin
            n_d          = msa_pkg::CNT_W'(mcnt_q[ch_q]);
            mcnt_d[ch_q] = '0;
          end
          msa_pkg::LVL_HOUR: begin
            n_d          = msa_pkg::CNT_W'(tcnt_q[ch_q]);
            tcnt_d[ch_q] = '0;
          end
          msa_pkg::LVL_DAY: begin
            n_d          = msa_pkg::CNT_W'(hcnt_q[ch_q]);
            hcnt_d[ch_q] = '0;
          end
          default: begin
            state_d = msa_pkg::ST_IDLE;
          end
        endcase
      end
      msa_pkg::ST_SCAN: begin
        // one read per cycle, data in the next cycle
        if (idx_q < n_eff) begin
          idx_d    = idx_q + 1'b1;
          rd_vld_d = 1'b1;
          unique case (item_q.rollup_level)
            msa_pkg::LVL_MINUTE: sec_re = 1'b1;
            msa_pkg::LVL_TENMIN: min_re = 1'b1;
            msa_pkg::LVL_HOUR:   ten_re = 1'b1;
            default:             hr_re  = 1'b1;
          endcase
        end
        if (rd_vld_q) begin
          first_d = 1'b0;
          sum_d   = sum_q + msa_pkg::SUM_W'(rd_avg);
          if (first_q || (rd_min < min_q)) begin
            min_d = rd_min;
          end
          if (first_q || (rd_max > max_q)) begin
            max_d = rd_max;
          end
        end
        if ((idx_q == n_eff) && !rd_vld_q) begin
          div_start = 1'b1;
          state_d   = msa_pkg::ST_DIV;
        end
      end
      msa_pkg::ST_DIV: begin
        if (div_done) begin
          res_d.out_channel  = item_q.channel;
          res_d.level        = item_q.rollup_level;
          res_d.average      = avg_res;
          res_d.minimum      = min_q;
          res_d.maximum      = max_q;
          res_d.entries_used = n_q[msa_pkg::USED_W-1:0];
          res_vld_d          = 1'b1;
          state_d            = msa_pkg::ST_IDLE;
          // append to the next level unless it is full; a day rollup appends nowhere
          unique case (item_q.rollup_level)
            msa_pkg::LVL_MINUTE: begin
              if (32'(mcnt_q[ch_q]) < MINUTE_DEPTH) begin
                min_we       = 1'b1;
                mcnt_d[ch_q] = mcnt_q[ch_q] + 1'b1;
              end
            end
            msa_pkg::LVL_TENMIN: begin
              if (32'(tcnt_q[ch_q]) < TENMIN_DEPTH) begin
                ten_we       = 1'b1;
                tcnt_d[ch_q] = tcnt_q[ch_q] + 1'b1;
              end
            end
            msa_pkg::LVL_HOUR: begin
              if (32'(hcnt_q[ch_q]) < HOUR_DEPTH) begin
                hr_we        = 1'b1;
                hcnt_d[ch_q] = hcnt_q[ch_q] + 1'b1;
              end
            end
            default: begin
              res_d.level = msa_pkg::LVL_DAY;
            end
          endcase
        end
      end
      default: begin
        state_d = msa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= msa_pkg::ST_CLR;
      clr_q     <= '0;
      limit_q   <= msa_pkg::LIMIT_RESET;
      rd_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
      ch_q      <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        miss_q[i] <= '0;
        scnt_q[i] <= '0;
        mcnt_q[i] <= '0;
        tcnt_q[i] <= '0;
        hcnt_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      limit_q   <= limit_d;
      rd_vld_q  <= rd_vld_d;
      res_vld_q <= res_vld_d;
      ch_q      <= ch_d;
      miss_q    <= miss_d;
      scnt_q    <= scnt_d;
      mcnt_q    <= mcnt_d;
      tcnt_q    <= tcnt_d;
      hcnt_q    <= hcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    n_q     <= n_d;
    idx_q   <= idx_d;
    first_q <= first_d;
    sum_q   <= sum_d;
    min_q   <= min_d;
    max_q   <= max_d;
    res_q   <= res_d;
  end

  // stores
  msa_ram #(.WIDTH(DW), .DEPTH(1 << SAW)) u_sec_ram (
    .clk_i(clk_i), .we_i(sec_we), .waddr_i(sec_waddr), .wdata_i(sec_wdata),
    .re_i(sec_re), .raddr_i(sec_raddr), .rdata_o(sec_rdata)
  );

  msa_ram #(.WIDTH(LW), .DEPTH(1 << MAW)) u_min_ram (
    .clk_i(clk_i), .we_i(min_we), .waddr_i(min_waddr), .wdata_i(min_wdata),
    .re_i(min_re), .raddr_i(min_raddr), .rdata_o(min_rdata)
  );

  msa_ram #(.WIDTH(LW), .DEPTH(1 << TAW)) u_ten_ram (
    .clk_i(clk_i), .we_i(ten_we), .waddr_i(ten_waddr), .wdata_i(ten_wdata),
    .re_i(ten_re), .raddr_i(ten_raddr), .rdata_o(ten_rdata)
  );

  msa_ram #(.WIDTH(LW), .DEPTH(1 << HAW)) u_hr_ram (
    .clk_i(clk_i), .we_i(hr_we), .waddr_i(hr_waddr), .wdata_i(hr_wdata),
    .re_i(hr_re), .raddr_i(hr_raddr), .rdata_o(hr_rdata)
  );

  // average divider
  msa_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start),
    .dividend_i(sum_q), .divisor_i(n_q), .done_o(div_done), .quot_o(div_quot)
  );

  assign busy           = (state_q != msa_pkg::ST_IDLE);
  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;
  assign cfg_ready_o    = 1'b1;

  // a result only follows a finished divide
  `MSA_ASSERT_IMP(a_res_after_div, clk_i, rst_ni, result_valid_o,
                  $past(state_q == msa_pkg::ST_DIV) && $past(div_done))
  // the divider only finishes while a rollup waits for it
  `MSA_ASSERT_IMP(a_div_in_state, clk_i, rst_ni, div_done, state_q == msa_pkg::ST_DIV)
  // the scan never issues past the entry count
  `MSA_ASSERT_IMP(a_scan_bound, clk_i, rst_ni, state_q == msa_pkg::ST_SCAN, idx_q <= n_eff)
  // the second count of the active channel stays within its depth
  `MSA_ASSERT(a_scnt_bound, clk_i, rst_ni, 32'(scnt_q[ch_q]) <= SECOND_DEPTH)

endmodule

`default_nettype wire

FILE: rtl/msa_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module msa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [((DEPTH>1)?$clog2(DEPTH):1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [((DEPTH>1)?$clog2(DEPTH):1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/msa_div.sv
`timescale 1ns / 1ps
`default_nettype none

module msa_div (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic signed [msa_pkg::SUM_W-1:0]    dividend_i,
  input  wire logic        [msa_pkg::CNT_W-1:0]    divisor_i,
  output logic                                     done_o,
  output logic signed [msa_pkg::DATA_W-1:0]        quot_o
);

  localparam int unsigned STEP_W = $clog2(msa_pkg::SUM_W + 1);

  logic                        run_q, run_d;
  logic [STEP_W-1:0]           step_q, step_d;
  logic                        neg_q, neg_d;
  logic [msa_pkg::SUM_W-1:0]   mag_q, mag_d;
  logic [msa_pkg::CNT_W:0]     rem_q, rem_d;
  logic [msa_pkg::CNT_W:0]     rem_sh;
  logic                        done_q, done_d;
  logic [msa_pkg::SUM_W-1:0]   quot_full;

  // restoring division on the magnitude, one quotient bit per cycle
  always_comb begin
    run_d  = run_q;
    step_d = step_q;
    neg_d  = neg_q;
    mag_d  = mag_q;
    rem_d  = rem_q;
    done_d = 1'b0;
    rem_sh = {rem_q[msa_pkg::CNT_W-1:0], mag_q[msa_pkg::SUM_W-1]};
    if (start_i) begin
      run_d  = 1'b1;
      step_d = STEP_W'(msa_pkg::SUM_W);
      neg_d  = dividend_i[msa_pkg::SUM_W-1];
      mag_d  = dividend_i[msa_pkg::SUM_W-1] ? (~dividend_i + 1'b1) : dividend_i;
      rem_d  = '0;
    end else if (run_q) begin
      if (rem_sh >= {1'b0, divisor_i}) begin
        rem_d = rem_sh - {1'b0, divisor_i};
        mag_d = {mag_q[msa_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        mag_d = {mag_q[msa_pkg::SUM_W-2:0], 1'b0};
      end
      step_d = step_q - 1'b1;
      if (step_q == STEP_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    mag_q <= mag_d;
    rem_q <= rem_d;
  end

  assign quot_full = neg_q ? (~mag_q + 1'b1) : mag_q;
  assign quot_o    = quot_full[msa_pkg::DATA_W-1:0];
  assign done_o    = done_q;

endmodule

`default_nettype wire
